// ===== sv/chp_pkg.sv =====
// Shared types and constants for the chunk header parser.
// No dependencies; every other file imports this package.
package chp_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
    localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

    localparam logic [5:0]  ID_MASK   = 6'h3F;
    localparam logic [16:0] ID_OFFSET = 17'd64;
    localparam logic [31:0] TS_ESCAPE = 32'h00FF_FFFF;
    localparam int unsigned FMT_SHIFT = 6;

    localparam logic [1:0] FMT_FULL    = 2'd0;
    localparam logic [1:0] FMT_NO_MSID = 2'd1;
    localparam logic [1:0] FMT_TIME    = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  fmt_code;
        logic [16:0] chunk_stream;
        logic [31:0] time_value;
        logic [23:0] body_length;
        logic [7:0]  content_kind;
        logic [31:0] msg_stream;
        logic [4:0]  header_length;
        logic        extended_used;
    } out_item_t;

    // A byte after the front end has classified it as a possible first byte.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       restart;
        logic [1:0] fmt;
        logic [5:0] id;
        logic       id_zero;
        logic       id_one;
    } front_item_t;

endpackage

// ===== sv/chp_in_if.sv =====
// Input channel of the chunk header parser: one header byte per transaction.
// Depends on chp_pkg for the payload type.
interface chp_in_if;
    import chp_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/chp_out_if.sv =====
// Output channel of the chunk header parser: one parsed header per transaction.
// Depends on chp_pkg for the payload type.
interface chp_out_if;
    import chp_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/chp_front.sv =====
// Front end: registers each incoming byte and decodes its first-byte fields.
// Depends on chp_pkg and chp_in_if.
module chp_front (
    input  logic                clk,
    input  logic                rst_n,
    chp_in_if.sink              bytes,
    output logic                item_valid,
    output chp_pkg::front_item_t item,
    input  logic                item_ready
);
    import chp_pkg::*;

    logic        valid_reg;
    front_item_t item_reg;
    front_item_t item_next;

    always_comb
    begin
        item_next.in_byte = bytes.data.in_byte;
        item_next.restart = bytes.data.restart;
        item_next.fmt     = bytes.data.in_byte[FMT_SHIFT +: 2];
        item_next.id      = bytes.data.in_byte[5:0] & ID_MASK;
        item_next.id_zero = (item_next.id == 6'd0);
        item_next.id_one  = (item_next.id == 6'd1);
    end

    // The register takes a new byte whenever it is empty or its byte moves on.
    assign bytes.ready = !valid_reg || item_ready;
    assign item_valid  = valid_reg;
    assign item        = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (bytes.ready)
        begin
            valid_reg <= bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.ready && bytes.valid)
        begin
            item_reg <= item_next;
        end
    end
endmodule

// ===== sv/chp_queue.sv =====
// Short queue between the front end and the parser back end.
// Depends on chp_pkg for the item type and depth.
module chp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  chp_pkg::front_item_t push_item,
    output logic                 push_ready,
    output logic                 pop_valid,
    output chp_pkg::front_item_t pop_item,
    input  logic                 pop_ready
);
    import chp_pkg::*;

    front_item_t             slot_reg [QueueDepth];
    logic [QueuePtrW-1:0]    wr_ptr_reg;
    logic [QueuePtrW-1:0]    rd_ptr_reg;
    logic [QueueCntW-1:0]    count_reg;
    logic                    do_push;
    logic                    do_pop;

    assign push_ready = (count_reg != QueueCntW'(QueueDepth));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

// ===== sv/chp_back.sv =====
// Back end: header field state machine, retained header values and result register.
// Depends on chp_pkg and chp_out_if.
module chp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  chp_pkg::front_item_t item,
    output logic                 item_ready,
    chp_out_if.source            headers
);
    import chp_pkg::*;

    typedef enum logic [2:0] {
        PH_BASIC,
        PH_ID_LO,
        PH_ID_HI,
        PH_TIME,
        PH_SIZE,
        PH_TYPE,
        PH_MSID,
        PH_EXT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  count_reg, count_next;
    logic [2:0]  left_reg, left_next;
    logic [31:0] acc_reg, acc_next;
    logic        two_reg, two_next;
    logic        ext_reg, ext_next;

    logic [1:0]  wfmt_reg, wfmt_next;
    logic [16:0] wstream_reg, wstream_next;
    logic [31:0] wtime_reg, wtime_next;
    logic [23:0] wsize_reg, wsize_next;
    logic [7:0]  wtype_reg, wtype_next;
    logic [31:0] wmsid_reg, wmsid_next;

    logic [16:0] hstream_reg;
    logic [31:0] htime_reg;
    logic [23:0] hsize_reg;
    logic [7:0]  htype_reg;
    logic [31:0] hmsid_reg;

    logic        out_valid_reg;
    out_item_t   out_reg;

    logic        step;
    logic        adv;
    phase_t      adv_from;
    logic        go_msid;
    logic        done;
    logic [31:0] acc_shift;
    logic [2:0]  left_dec;

    assign item_ready = !out_valid_reg || headers.ready;
    assign step       = item_valid && item_ready;

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        left_next    = left_reg;
        acc_next     = acc_reg;
        two_next     = two_reg;
        ext_next     = ext_reg;
        wfmt_next    = wfmt_reg;
        wstream_next = wstream_reg;
        wtime_next   = wtime_reg;
        wsize_next   = wsize_reg;
        wtype_next   = wtype_reg;
        wmsid_next   = wmsid_reg;
        adv          = 1'b0;
        adv_from     = PH_BASIC;
        go_msid      = 1'b0;
        done         = 1'b0;
        left_dec     = (left_reg != 3'd0) ? (left_reg - 3'd1) : 3'd0;

        // Both stream ids arrive low byte first; the other fields are big-endian.
        case (3'(3'd4 - left_reg) & 3'd3)
            3'd0:    acc_shift = {24'd0, item.in_byte};
            3'd1:    acc_shift = {16'd0, item.in_byte, 8'd0};
            3'd2:    acc_shift = {8'd0, item.in_byte, 16'd0};
            3'd3:    acc_shift = {item.in_byte, 24'd0};
            default: acc_shift = '0;
        endcase

        if (item.restart || phase_reg == PH_BASIC)
        begin
            count_next   = 5'd1;
            wfmt_next    = item.fmt;
            wstream_next = {11'd0, item.id};
            wtime_next   = htime_reg;
            wsize_next   = hsize_reg;
            wtype_next   = htype_reg;
            wmsid_next   = hmsid_reg;
            ext_next     = 1'b0;
            two_next     = item.id_one;
            if (item.id_zero || item.id_one)
            begin
                phase_next = PH_ID_LO;
                left_next  = 3'd1;
                acc_next   = '0;
            end
            else
            begin
                adv      = 1'b1;
                adv_from = PH_BASIC;
            end
        end
        else
        begin
            count_next = count_reg + 5'd1;
            case (phase_reg)
                PH_ID_LO:
                begin
                    wstream_next = {9'd0, item.in_byte} + ID_OFFSET;
                    if (two_reg)
                    begin
                        phase_next = PH_ID_HI;
                        left_next  = 3'd1;
                        acc_next   = '0;
                    end
                    else
                    begin
                        adv      = 1'b1;
                        adv_from = PH_ID_LO;
                    end
                end
                PH_ID_HI:
                begin
                    wstream_next = wstream_reg + {1'b0, item.in_byte, 8'd0};
                    adv          = 1'b1;
                    adv_from     = PH_ID_HI;
                end
                default:
                begin
                    if (phase_reg == PH_MSID)
                    begin
                        acc_next = acc_reg | acc_shift;
                    end
                    else
                    begin
                        acc_next = {acc_reg[23:0], item.in_byte};
                    end
                    left_next = left_dec;
                    if (left_dec == 3'd0)
                    begin
                        case (phase_reg)
                            PH_TIME: wtime_next = {8'd0, acc_next[23:0]};
                            PH_SIZE: wsize_next = acc_next[23:0];
                            PH_TYPE: wtype_next = acc_next[7:0];
                            PH_MSID: wmsid_next = acc_next;
                            default:
                            begin
                                wtime_next = acc_next;
                                ext_next   = 1'b1;
                            end
                        endcase
                        adv      = 1'b1;
                        adv_from = phase_reg;
                    end
                end
            endcase
        end

        // Pick the next field the format carries, or finish the header.
        if (adv)
        begin
            case (adv_from)
                PH_BASIC, PH_ID_LO, PH_ID_HI:
                begin
                    if (wfmt_next <= FMT_TIME)
                    begin
                        phase_next = PH_TIME;
                        left_next  = 3'd3;
                        acc_next   = '0;
                    end
                    else
                    begin
                        go_msid = 1'b1;
                    end
                end
                PH_TIME:
                begin
                    if (wfmt_next <= FMT_NO_MSID)
                    begin
                        phase_next = PH_SIZE;
                        left_next  = 3'd3;
                        acc_next   = '0;
                    end
                    else
                    begin
                        go_msid = 1'b1;
                    end
                end
                PH_SIZE:
                begin
                    phase_next = PH_TYPE;
                    left_next  = 3'd1;
                    acc_next   = '0;
                end
                PH_TYPE:
                begin
                    if (wfmt_next == FMT_FULL)
                    begin
                        phase_next = PH_MSID;
                        left_next  = 3'd4;
                        acc_next   = '0;
                    end
                    else
                    begin
                        go_msid = 1'b1;
                    end
                end
                PH_MSID:
                begin
                    go_msid = 1'b1;
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase

            if (go_msid)
            begin
                if (wtime_next == TS_ESCAPE)
                begin
                    phase_next = PH_EXT;
                    left_next  = 3'd4;
                    acc_next   = '0;
                end
                else
                begin
                    done = 1'b1;
                end
            end
        end

        if (done)
        begin
            phase_next = PH_BASIC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BASIC;
            count_reg     <= '0;
            left_reg      <= '0;
            acc_reg       <= '0;
            two_reg       <= 1'b0;
            ext_reg       <= 1'b0;
            wfmt_reg      <= '0;
            wstream_reg   <= '0;
            wtime_reg     <= '0;
            wsize_reg     <= '0;
            wtype_reg     <= '0;
            wmsid_reg     <= '0;
            hstream_reg   <= '0;
            htime_reg     <= '0;
            hsize_reg     <= '0;
            htype_reg     <= '0;
            hmsid_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (step && done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (headers.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (step)
            begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                left_reg    <= left_next;
                acc_reg     <= acc_next;
                two_reg     <= two_next;
                ext_reg     <= ext_next;
                wfmt_reg    <= wfmt_next;
                wstream_reg <= wstream_next;
                wtime_reg   <= wtime_next;
                wsize_reg   <= wsize_next;
                wtype_reg   <= wtype_next;
                wmsid_reg   <= wmsid_next;
                if (done)
                begin
                    hstream_reg           <= wstream_next;
                    htime_reg             <= wtime_next;
                    hsize_reg             <= wsize_next;
                    htype_reg             <= wtype_next;
                    hmsid_reg             <= wmsid_next;
                    out_reg.fmt_code      <= wfmt_next;
                    out_reg.chunk_stream  <= wstream_next;
                    out_reg.time_value    <= wtime_next;
                    out_reg.body_length   <= wsize_next;
                    out_reg.content_kind  <= wtype_next;
                    out_reg.msg_stream    <= wmsid_next;
                    out_reg.header_length <= count_next;
                    out_reg.extended_used <= ext_next;
                end
            end
        end
    end

    assign headers.valid = out_valid_reg;
    assign headers.data  = out_reg;
endmodule

// ===== sv/chunk_header_parser.sv =====
// Top level of the chunk header parser: front end, queue and parser back end.
// Depends on chp_pkg, chp_in_if, chp_out_if, chp_front, chp_queue and chp_back.
//
//   Channel   Direction  Transaction
//   bytes     in         one header byte with its restart flag
//   headers   out        one completed header: all fields and its length
//
// One byte is taken per cycle while the output is not stalled; the back end's field
// state machine handles one byte a cycle, so the sustained rate is one byte per clock.
// A byte passes through the front end register and then a queue slot before it reaches
// the back end; a header is offered on the cycle after its last byte is parsed.
// Reset clears the parse state and the retained header values to zero.
// A stalled output holds the back end; the four-entry queue and the front end
// register keep the input open until both fill.
module chunk_header_parser (
    input  logic       clk,
    input  logic       rst_n,
    chp_in_if.sink     bytes,
    chp_out_if.source  headers
);
    import chp_pkg::*;

    logic        front_valid;
    front_item_t front_item;
    logic        front_ready;
    logic        queue_valid;
    front_item_t queue_item;
    logic        queue_ready;

    chp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .item_valid (front_valid),
        .item       (front_item),
        .item_ready (front_ready)
    );

    chp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_item  (front_item),
        .push_ready (front_ready),
        .pop_valid  (queue_valid),
        .pop_item   (queue_item),
        .pop_ready  (queue_ready)
    );

    chp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (queue_valid),
        .item       (queue_item),
        .item_ready (queue_ready),
        .headers    (headers)
    );
endmodule

// ===== tb/chunk_header_parser_tb.sv =====
// Self-checking testbench for chunk_header_parser: directed header bytes, then random headers.
// Depends on chp_pkg, chp_in_if, chp_out_if and the chunk_header_parser RTL.
// Each parsed header is checked against a predictor that runs alongside the stimulus.
module chunk_header_parser_tb;
    import chp_pkg::*;

    localparam logic [1:0]  FMT_SHORT    = 2'd3;
    localparam int unsigned RANDOM_BYTES = 450;
    localparam int unsigned LONG_HOLD    = 120;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned SETTLE       = 20;
    localparam int unsigned DIR_N        = 26;

    // Where the parser stands within a header.
    typedef enum logic [2:0] {
        SEEK_FIRST, SEEK_ID_LO, SEEK_ID_HI, SEEK_STAMP,
        SEEK_SIZE, SEEK_KIND, SEEK_MSID, SEEK_EXT
    } seek_t;

    typedef struct packed {
        logic [7:0] b;
        logic       rs;
        logic       typed;
        out_item_t  want;
    } dir_row_t;

    // Directed bytes. A typed row carries its header as read straight off the byte sequence.
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // Right after reset: a one-byte format 3 header repeats the all-zero retained fields.
        '{8'hC2, 1'b0, 1'b1, '{FMT_SHORT, 17'd2, 32'd0, 24'd0, 8'd0, 32'd0, 5'd1, 1'b0}},
        // Longest header: format 0, three-byte id at its maximum, escaped timestamp.
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b1, '{FMT_FULL, 17'd65599, 32'h00FF_FFFF, 24'hFF_FFFF, 8'hFF,
                               32'hFFFF_FFFF, 5'd18, 1'b1}},
        // A format 1 header cut short by a restart.
        '{8'h45, 1'b0, 1'b0, '0},
        '{8'h12, 1'b0, 1'b0, '0},
        // The retained extended value equals the escape, so format 3 needs four more bytes.
        '{8'hC3, 1'b1, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{FMT_SHORT, 17'd3, 32'd0, 24'hFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
                               5'd5, 1'b1}}
    };

    logic clk;
    logic rst_n;

    chp_in_if  in_ch ();
    chp_out_if out_ch ();

    chunk_header_parser uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (in_ch),
        .headers (out_ch)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Parser state as the predictor sees it.
    seek_t       phase       = SEEK_FIRST;
    logic [4:0]  nbytes      = '0;
    int unsigned left        = 0;
    logic [31:0] acc         = '0;
    logic [1:0]  cur_fmt     = '0;
    logic [16:0] cur_stream  = '0;
    logic [31:0] cur_time    = '0;
    logic [23:0] cur_size    = '0;
    logic [7:0]  cur_kind    = '0;
    logic [31:0] cur_msid    = '0;
    logic        cur_ext     = 1'b0;
    logic        cur_wide_id = 1'b0;
    logic [31:0] kept_time   = '0;
    logic [23:0] kept_size   = '0;
    logic [7:0]  kept_kind   = '0;
    logic [31:0] kept_msid   = '0;

    out_item_t   pending_headers [$];
    logic [7:0]  hdr_seq [$];

    int unsigned burst_left = 0;
    int unsigned n_bytes    = 0;
    int unsigned n_restarts = 0;
    int unsigned n_headers  = 0;
    int unsigned n_extended = 0;
    int unsigned errors     = 0;
    int unsigned quiet      = 0;
    int unsigned fmt_seen [4] = '{0, 0, 0, 0};
    logic        hold_req;

    function automatic void open_field(input seek_t ph, input int unsigned len);
        phase = ph;
        left  = len;
        acc   = '0;
    endfunction

    // Picks the field after the one just finished; returns 1 when the header is complete.
    function automatic bit finish_field(input seek_t ph);
        if (ph == SEEK_FIRST || ph == SEEK_ID_LO || ph == SEEK_ID_HI)
        begin
            if (cur_fmt <= FMT_TIME)
            begin
                open_field(SEEK_STAMP, 3);
                return 1'b0;
            end
        end
        else if (ph == SEEK_STAMP)
        begin
            if (cur_fmt <= FMT_NO_MSID)
            begin
                open_field(SEEK_SIZE, 3);
                return 1'b0;
            end
        end
        else if (ph == SEEK_SIZE)
        begin
            open_field(SEEK_KIND, 1);
            return 1'b0;
        end
        else if (ph == SEEK_KIND)
        begin
            if (cur_fmt == FMT_FULL)
            begin
                open_field(SEEK_MSID, 4);
                return 1'b0;
            end
        end
        else if (ph == SEEK_EXT)
        begin
            return 1'b1;
        end
        if (cur_time == TS_ESCAPE)
        begin
            open_field(SEEK_EXT, 4);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic rs, output bit made);
        bit        done;
        logic [5:0] id;
        out_item_t hdr;
        if (rs || phase == SEEK_FIRST)
        begin
            id          = b[5:0] & ID_MASK;
            nbytes      = 5'd1;
            cur_fmt     = b[7:6];
            cur_stream  = {11'd0, id};
            cur_time    = kept_time;
            cur_size    = kept_size;
            cur_kind    = kept_kind;
            cur_msid    = kept_msid;
            cur_ext     = 1'b0;
            cur_wide_id = (id == 6'd1);
            if (id <= 6'd1)
            begin
                open_field(SEEK_ID_LO, 1);
                done = 1'b0;
            end
            else
            begin
                done = finish_field(SEEK_FIRST);
            end
        end
        else
        begin
            nbytes = nbytes + 5'd1;
            if (phase == SEEK_ID_LO)
            begin
                cur_stream = {9'd0, b} + ID_OFFSET;
                if (cur_wide_id)
                begin
                    open_field(SEEK_ID_HI, 1);
                    done = 1'b0;
                end
                else
                begin
                    done = finish_field(SEEK_ID_LO);
                end
            end
            else if (phase == SEEK_ID_HI)
            begin
                cur_stream = cur_stream + {1'b0, b, 8'h00};
                done = finish_field(SEEK_ID_HI);
            end
            else
            begin
                // Of the fields gathered here, the message stream id is the one little-endian field.
                if (phase == SEEK_MSID)
                    acc = acc | (32'(b) << (8 * ((4 - left) & 3)));
                else
                    acc = {acc[23:0], b};
                left--;
                done = 1'b0;
                if (left == 0)
                begin
                    case (phase)
                        SEEK_STAMP: cur_time = {8'd0, acc[23:0]};
                        SEEK_SIZE:  cur_size = acc[23:0];
                        SEEK_KIND:  cur_kind = acc[7:0];
                        SEEK_MSID:  cur_msid = acc;
                        default:
                        begin
                            cur_time = acc;
                            cur_ext  = 1'b1;
                        end
                    endcase
                    done = finish_field(phase);
                end
            end
        end
        made = done;
        if (done)
        begin
            kept_time = cur_time;
            kept_size = cur_size;
            kept_kind = cur_kind;
            kept_msid = cur_msid;
            phase     = SEEK_FIRST;
            hdr.fmt_code      = cur_fmt;
            hdr.chunk_stream  = cur_stream;
            hdr.time_value    = cur_time;
            hdr.body_length   = cur_size;
            hdr.content_kind  = cur_kind;
            hdr.msg_stream    = cur_msid;
            hdr.header_length = nbytes;
            hdr.extended_used = cur_ext;
            pending_headers.push_back(hdr);
        end
    endtask

    // Offers one byte, holding it until the parser takes it; bursts and gaps are random.
    task automatic send_byte(input logic [7:0] b, input logic rs, output bit made);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{in_byte: b, restart: rs};
        do
            @(posedge clk);
        while (!in_ch.ready);
        burst_left--;
        n_bytes++;
        if (rs)
            n_restarts++;
        predict_byte(b, rs, made);
    endtask

    // Builds a well-formed header with random content into hdr_seq.
    task automatic build_header();
        logic [1:0]  fmt;
        logic [5:0]  id;
        logic [31:0] word;
        int unsigned pick;
        bit          wants_ext;
        hdr_seq.delete();
        fmt  = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        id   = (pick == 0) ? 6'd0 : (pick == 1) ? 6'd1 : 6'($urandom_range(2, 63));
        hdr_seq.push_back({fmt, id});
        if (id == 6'd0)
            hdr_seq.push_back(8'($urandom));
        if (id == 6'd1)
        begin
            hdr_seq.push_back(8'($urandom));
            hdr_seq.push_back(8'($urandom));
        end
        if (fmt != FMT_SHORT)
        begin
            word = ($urandom_range(0, 3) == 0) ? TS_ESCAPE : {8'd0, 24'($urandom)};
            hdr_seq.push_back(word[23:16]);
            hdr_seq.push_back(word[15:8]);
            hdr_seq.push_back(word[7:0]);
            wants_ext = (word == TS_ESCAPE);
        end
        else
        begin
            wants_ext = (kept_time == TS_ESCAPE);
        end
        if (fmt <= FMT_NO_MSID)
        begin
            word = $urandom;
            hdr_seq.push_back(word[23:16]);
            hdr_seq.push_back(word[15:8]);
            hdr_seq.push_back(word[7:0]);
            hdr_seq.push_back(8'($urandom));
        end
        if (fmt == FMT_FULL)
        begin
            word = $urandom;
            hdr_seq.push_back(word[7:0]);
            hdr_seq.push_back(word[15:8]);
            hdr_seq.push_back(word[23:16]);
            hdr_seq.push_back(word[31:24]);
        end
        if (wants_ext)
        begin
            word = ($urandom_range(0, 3) == 0) ? TS_ESCAPE : $urandom;
            hdr_seq.push_back(word[31:24]);
            hdr_seq.push_back(word[23:16]);
            hdr_seq.push_back(word[15:8]);
            hdr_seq.push_back(word[7:0]);
        end
    endtask

    function automatic void report(input string what, input out_item_t want,
                                   input out_item_t got);
        errors++;
        if (errors <= 10)
        begin
            $display("ERROR %s", what);
            $display("  expected fmt=%0d stream=%0d time=%h size=%h kind=%h msid=%h len=%0d ext=%0d",
                     want.fmt_code, want.chunk_stream, want.time_value, want.body_length,
                     want.content_kind, want.msg_stream, want.header_length,
                     want.extended_used);
            $display("  actual   fmt=%0d stream=%0d time=%h size=%h kind=%h msid=%h len=%0d ext=%0d",
                     got.fmt_code, got.chunk_stream, got.time_value, got.body_length,
                     got.content_kind, got.msg_stream, got.header_length, got.extended_used);
        end
    endfunction

    function automatic void check_header(input out_item_t got);
        out_item_t want;
        string     bad;
        if (pending_headers.size() == 0)
        begin
            report("header arrived with none expected", '0, got);
            return;
        end
        want = pending_headers.pop_front();
        bad  = "";
        if (got.fmt_code !== want.fmt_code)           bad = {bad, " fmt_code"};
        if (got.chunk_stream !== want.chunk_stream)   bad = {bad, " chunk_stream"};
        if (got.time_value !== want.time_value)       bad = {bad, " time_value"};
        if (got.body_length !== want.body_length)     bad = {bad, " body_length"};
        if (got.content_kind !== want.content_kind)   bad = {bad, " content_kind"};
        if (got.msg_stream !== want.msg_stream)       bad = {bad, " msg_stream"};
        if (got.header_length !== want.header_length) bad = {bad, " header_length"};
        if (got.extended_used !== want.extended_used) bad = {bad, " extended_used"};
        if (bad != "")
            report({"mismatch in", bad}, want, got);
        n_headers++;
        fmt_seen[want.fmt_code]++;
        if (want.extended_used)
            n_extended++;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            check_header(out_ch.data);
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles", quiet);
                $display("chunk_header_parser regression: fail");
                $finish;
            end
        end
    end

    // Output side: switches between free flow, random stalls and a fixed stall pattern,
    // and on request holds off for a long stretch so the parser backs up to its input.
    initial
    begin : receiver
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned beat;
        int unsigned mode;
        bit          hold_taken;
        out_ch.ready <= 1'b0;
        hold_left  = 0;
        mode_left  = 0;
        beat       = 0;
        mode       = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            beat++;
            if (hold_left != 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (hold_req && !hold_taken)
            begin
                hold_taken   = 1'b1;
                hold_left    = LONG_HOLD - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= ($urandom_range(0, 2) != 0);
                    default: out_ch.ready <= ((beat % 5) >= 2);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int unsigned cut;
        logic        rs;
        bit          made;
        bit          force_rs;
        bit          held_once;
        bit          drained_once;
        rst_n       <= 1'b0;
        hold_req    <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        force_rs     = 1'b0;
        held_once    = 1'b0;
        drained_once = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
        begin
            send_byte(DIR_ROWS[i].b, DIR_ROWS[i].rs, made);
            if (DIR_ROWS[i].typed)
            begin
                if (made)
                    void'(pending_headers.pop_back());
                pending_headers.push_back(DIR_ROWS[i].want);
            end
        end

        while (n_bytes < DIR_N + RANDOM_BYTES)
        begin
            if (!held_once && n_bytes >= DIR_N + 120)
            begin
                held_once  = 1'b1;
                hold_req   <= 1'b1;
                burst_left = 150;
            end
            if (!drained_once && n_bytes >= DIR_N + 300)
            begin
                drained_once = 1'b1;
                in_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_headers.size() != 0);
            end
            // Now and then a short run of raw noise bytes.
            if ($urandom_range(0, 14) == 0)
            begin
                repeat ($urandom_range(1, 5))
                    send_byte(8'($urandom), 1'($urandom_range(0, 1)), made);
                force_rs = (phase != SEEK_FIRST);
            end
            build_header();
            cut = hdr_seq.size();
            if (cut > 1 && $urandom_range(0, 9) == 0)
                cut = $urandom_range(1, cut - 1);
            for (int k = 0; k < cut; k++)
            begin
                if (k == 0)
                    rs = force_rs || ($urandom_range(0, 3) == 0);
                else
                    rs = ($urandom_range(0, 59) == 0);
                send_byte(hdr_seq[k], rs, made);
            end
            // A truncated or disrupted header must be abandoned with a restart.
            force_rs = (phase != SEEK_FIRST);
        end

        in_ch.valid <= 1'b0;
        while (pending_headers.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d bytes (%0d directed, %0d with restart); checked %0d headers, %0d extended.",
                 n_bytes, DIR_N, n_restarts, n_headers, n_extended);
        $display("Headers by format 0/1/2/3: %0d/%0d/%0d/%0d; one long output stall, one drain.",
                 fmt_seen[0], fmt_seen[1], fmt_seen[2], fmt_seen[3]);
        if (errors == 0)
        begin
            $display("chunk_header_parser regression: pass");
        end
        else
        begin
            $display("%0d errors", errors);
            $display("chunk_header_parser regression: fail");
        end
        $finish;
    end

endmodule

// ===== chunk_header_parser.f =====
sv/chp_pkg.sv
sv/chp_in_if.sv
sv/chp_out_if.sv
sv/chp_front.sv
sv/chp_queue.sv
sv/chp_back.sv
sv/chunk_header_parser.sv
tb/chunk_header_parser_tb.sv
